@@ sv/i2csbr_pkg.sv @@
package i2csbr_pkg;

  localparam int DEPTH  = 256;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PTR_W  = 9;

  localparam logic [PTR_W-1:0] DEPTH_PTR = PTR_W'(DEPTH);

  localparam logic [3:0] MODE_START     = 4'd0;
  localparam logic [3:0] MODE_STOP      = 4'd1;
  localparam logic [3:0] MODE_GEN_CALL  = 4'd2;
  localparam logic [3:0] MODE_BYTE_RX   = 4'd3;
  localparam logic [3:0] MODE_BYTE_REQ  = 4'd4;
  localparam logic [3:0] MODE_HOST_RD   = 4'd5;
  localparam logic [3:0] MODE_HOST_WR   = 4'd6;
  localparam logic [3:0] MODE_SET_FLAG  = 4'd7;
  localparam logic [3:0] MODE_ARM       = 4'd8;

  localparam logic [1:0] FLAG_RX_DONE = 2'd0;
  localparam logic [1:0] FLAG_TX_DONE = 2'd1;
  localparam logic [1:0] FLAG_GC      = 2'd2;

  localparam logic [7:0] TX_PAST_END = 8'hFF;

  typedef struct packed {
    logic [3:0] mode;
    logic [7:0] bus_byte;
    logic [7:0] host_index;
    logic [7:0] host_data;
    logic [1:0] flag_select;
    logic       flag_value;
  } req_t;

  typedef struct packed {
    logic [7:0]       bus_tx_byte;
    logic [7:0]       host_read_data;
    logic [7:0]       internal_address;
    logic             rx_done;
    logic             tx_done;
    logic             general_call_seen;
    logic [PTR_W-1:0] pointer;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

endpackage

@@ sv/i2csbr_ctrl.sv @@
module i2csbr_ctrl
  import i2csbr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output ctrl_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_RESP = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_RESP;
      end
      ST_RESP: begin
        if (rsp_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == ST_IDLE);
  assign rsp_valid = (state == ST_RESP);
  assign cmd.load  = req_ready && req_valid;
  assign cmd.exec  = (state == ST_EXEC);

endmodule

@@ sv/i2csbr_dp.sv @@
module i2csbr_dp
  import i2csbr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  ctrl_cmd_t        cmd,
  input  req_t             req,
  output rsp_t             rsp,
  input  logic             cfg_we,
  input  logic [PTR_W-1:0] cfg_wdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] mem_q;

  req_t             item;
  logic [PTR_W-1:0] buffer_size;
  logic [PTR_W-1:0] index;
  logic [7:0]       latched_address;
  logic             start_pending;
  logic             receiving;
  logic             sending;
  logic             rx_done;
  logic             tx_done;
  logic             gc;
  logic             tx_mem;
  logic             tx_ff;
  logic             hrd_mem;

  logic [PTR_W-1:0] index_next;
  logic [7:0]       latched_address_next;
  logic             start_pending_next;
  logic             receiving_next;
  logic             sending_next;
  logic             rx_done_next;
  logic             tx_done_next;
  logic             gc_next;
  logic             tx_mem_next;
  logic             tx_ff_next;
  logic             hrd_mem_next;

  logic [PTR_W-1:0]  lim;
  logic [PTR_W-1:0]  bus_ext;
  logic [PTR_W-1:0]  host_ext;
  logic [PTR_W-1:0]  eff;
  logic              mem_we;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [7:0]        wdata;

  always_comb begin
    lim      = (buffer_size > DEPTH_PTR) ? DEPTH_PTR : buffer_size;
    bus_ext  = {1'b0, item.bus_byte};
    host_ext = {1'b0, item.host_index};
    eff      = start_pending ? {1'b0, latched_address} : index;

    index_next           = index;
    latched_address_next = latched_address;
    start_pending_next   = start_pending;
    receiving_next       = receiving;
    sending_next         = sending;
    rx_done_next         = rx_done;
    tx_done_next         = tx_done;
    gc_next              = gc;
    tx_mem_next          = 1'b0;
    tx_ff_next           = 1'b0;
    hrd_mem_next         = 1'b0;
    mem_we               = 1'b0;
    waddr                = index[ADDR_W-1:0];
    wdata                = item.bus_byte;
    raddr                = eff[ADDR_W-1:0];

    case (item.mode)
      MODE_START: begin
        start_pending_next = 1'b1;
        index_next         = '0;
      end
      MODE_STOP: begin
        if (receiving) begin
          receiving_next = 1'b0;
          rx_done_next   = 1'b1;
        end
        if (sending) begin
          sending_next = 1'b0;
          tx_done_next = 1'b1;
        end
      end
      MODE_GEN_CALL: begin
        gc_next = 1'b1;
      end
      MODE_BYTE_RX: begin
        if (start_pending) begin
          start_pending_next = 1'b0;
          receiving_next     = 1'b1;
          if (bus_ext < lim) begin
            latched_address_next = item.bus_byte;
            index_next           = bus_ext;
          end else begin
            latched_address_next = '0;
            index_next           = '0;
          end
        end else if (index < lim) begin
          mem_we     = 1'b1;
          index_next = index + PTR_W'(1);
        end
      end
      MODE_BYTE_REQ: begin
        if (start_pending) begin
          start_pending_next = 1'b0;
          sending_next       = 1'b1;
        end
        if (eff < lim) begin
          tx_mem_next = 1'b1;
          index_next  = eff + PTR_W'(1);
        end else begin
          tx_ff_next = 1'b1;
          index_next = eff;
        end
      end
      MODE_HOST_RD: begin
        raddr        = item.host_index[ADDR_W-1:0];
        hrd_mem_next = (host_ext < DEPTH_PTR);
      end
      MODE_HOST_WR: begin
        waddr  = item.host_index[ADDR_W-1:0];
        wdata  = item.host_data;
        mem_we = (host_ext < DEPTH_PTR);
      end
      MODE_SET_FLAG: begin
        case (item.flag_select)
          FLAG_RX_DONE: rx_done_next = item.flag_value;
          FLAG_TX_DONE: tx_done_next = item.flag_value;
          FLAG_GC:      gc_next      = item.flag_value;
          default: begin
          end
        endcase
      end
      MODE_ARM: begin
        rx_done_next       = 1'b0;
        tx_done_next       = 1'b0;
        gc_next            = 1'b0;
        receiving_next     = 1'b0;
        sending_next       = 1'b0;
        start_pending_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (mem_we) begin
        mem[waddr] <= wdata;
      end
      mem_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size <= '0;
    end else if (cfg_we) begin
      buffer_size <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      index           <= '0;
      latched_address <= '0;
      start_pending   <= 1'b0;
      receiving       <= 1'b0;
      sending         <= 1'b0;
      rx_done         <= 1'b0;
      tx_done         <= 1'b0;
      gc              <= 1'b0;
      tx_mem          <= 1'b0;
      tx_ff           <= 1'b0;
      hrd_mem         <= 1'b0;
    end else if (cmd.exec) begin
      index           <= index_next;
      latched_address <= latched_address_next;
      start_pending   <= start_pending_next;
      receiving       <= receiving_next;
      sending         <= sending_next;
      rx_done         <= rx_done_next;
      tx_done         <= tx_done_next;
      gc              <= gc_next;
      tx_mem          <= tx_mem_next;
      tx_ff           <= tx_ff_next;
      hrd_mem         <= hrd_mem_next;
    end
  end

  always_comb begin
    if (tx_mem) begin
      rsp.bus_tx_byte = mem_q;
    end else if (tx_ff) begin
      rsp.bus_tx_byte = TX_PAST_END;
    end else begin
      rsp.bus_tx_byte = '0;
    end
    rsp.host_read_data    = hrd_mem ? mem_q : 8'h00;
    rsp.internal_address  = latched_address;
    rsp.rx_done           = rx_done;
    rsp.tx_done           = tx_done;
    rsp.general_call_seen = gc;
    rsp.pointer           = index;
  end

endmodule

@@ sv/i2c_slave_buffer_responder_unit.sv @@
// I2C slave buffer with an auto-incrementing pointer, fed with bus events and host accesses
// that arrive as requests, one response per request. Each request passes from acceptance
// through the execute state, where the buffer is accessed with registered read data, to the
// response, which waits for rsp_ready; a new request is taken only after the previous
// response has been taken. The buffer_size register is to be written through cfg_we and
// cfg_wdata only while no request is open; the block itself does not enforce this.
module i2c_slave_buffer_responder_unit
  import i2csbr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  req_t             req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output rsp_t             rsp,
  input  logic             cfg_we,
  input  logic [PTR_W-1:0] cfg_wdata
);

  ctrl_cmd_t cmd;

  i2csbr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd)
  );

  i2csbr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req       (req),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

endmodule

@@ sv/i2csbr_chk.sv @@
module i2csbr_chk
  import i2csbr_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_ready,
  input req_t             req,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input rsp_t             rsp,
  input logic             cfg_we,
  input logic [PTR_W-1:0] cfg_wdata
);

  // A request is never taken while a response is still being offered.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(req_ready && rsp_valid))
    else $error("request ready while response valid");

  // Every accepted request passes through the execute state and then offers its response.
  a_rsp_latency: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> ##1 rsp_valid)
    else $error("response missing after accepted request");

  // A stalled response keeps its contents.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled response changed");

  // The pointer never runs past the buffer depth.
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.pointer <= DEPTH_PTR))
    else $error("pointer beyond buffer depth");

endmodule

bind i2c_slave_buffer_responder_unit i2csbr_chk u_chk (.*);

@@ dv/i2c_slave_buffer_responder_unit_checker.sv @@
`timescale 1ns / 1ps
module i2c_slave_buffer_responder_unit_checker
  import i2csbr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic             req_ready,
  input  req_t             req,
  input  logic             rsp_valid,
  input  logic             rsp_ready,
  input  rsp_t             rsp,
  input  logic             cfg_we,
  input  logic [PTR_W-1:0] cfg_wdata,
  output int               fail_total,
  output int               open_count
);

  logic [7:0]       mem [DEPTH];
  logic [PTR_W-1:0] size_reg;
  logic [PTR_W-1:0] ptr;
  logic [7:0]       addr_latch;
  logic             await_addr;
  logic             in_write;
  logic             in_read;
  logic             rx_done_q;
  logic             tx_done_q;
  logic             gc_q;

  rsp_t rsp_due [$];
  int   mismatches = 0;
  int   responses = 0;

  task automatic note_mismatch(input string what, input logic [8:0] got,
                               input logic [8:0] want);
    $display("mismatch at response %0d: %s got %h expected %h", responses, what, got, want);
    mismatches++;
  endtask

  // Applies one request to the slave state and returns the response it should produce.
  task automatic advance_slave(input req_t r, output rsp_t o);
    int         lim;
    logic [7:0] tx;
    logic [7:0] hrd;
    lim = (size_reg > DEPTH_PTR) ? DEPTH : int'(size_reg);
    tx = 8'h00;
    hrd = 8'h00;
    case (r.mode)
      MODE_START: begin
        await_addr = 1'b1;
        ptr = '0;
      end
      MODE_STOP: begin
        if (in_write) begin
          in_write = 1'b0;
          rx_done_q = 1'b1;
        end
        if (in_read) begin
          in_read = 1'b0;
          tx_done_q = 1'b1;
        end
      end
      MODE_GEN_CALL: gc_q = 1'b1;
      MODE_BYTE_RX: begin
        if (await_addr) begin
          await_addr = 1'b0;
          in_write = 1'b1;
          addr_latch = (r.bus_byte < lim) ? r.bus_byte : 8'h00;
          ptr = {1'b0, addr_latch};
        end else if (ptr < lim) begin
          mem[ptr[7:0]] = r.bus_byte;
          ptr = ptr + 1'b1;
        end
      end
      MODE_BYTE_REQ: begin
        if (await_addr) begin
          await_addr = 1'b0;
          in_read = 1'b1;
          ptr = {1'b0, addr_latch};
        end
        if (ptr < lim) begin
          tx = mem[ptr[7:0]];
          ptr = ptr + 1'b1;
        end else begin
          tx = TX_PAST_END;
        end
      end
      MODE_HOST_RD: hrd = mem[r.host_index];
      MODE_HOST_WR: mem[r.host_index] = r.host_data;
      MODE_SET_FLAG: begin
        case (r.flag_select)
          FLAG_RX_DONE: rx_done_q = r.flag_value;
          FLAG_TX_DONE: tx_done_q = r.flag_value;
          FLAG_GC:      gc_q = r.flag_value;
          default: ;
        endcase
      end
      MODE_ARM: begin
        rx_done_q = 1'b0;
        tx_done_q = 1'b0;
        gc_q = 1'b0;
        in_write = 1'b0;
        in_read = 1'b0;
        await_addr = 1'b0;
      end
      default: ;
    endcase
    o.bus_tx_byte = tx;
    o.host_read_data = hrd;
    o.internal_address = addr_latch;
    o.rx_done = rx_done_q;
    o.tx_done = tx_done_q;
    o.general_call_seen = gc_q;
    o.pointer = ptr;
  endtask

  always @(posedge clk) begin
    rsp_t want;
    rsp_t fresh;
    if (rst) begin
      size_reg = '0;
      ptr = '0;
      addr_latch = '0;
      await_addr = 1'b0;
      in_write = 1'b0;
      in_read = 1'b0;
      rx_done_q = 1'b0;
      tx_done_q = 1'b0;
      gc_q = 1'b0;
      rsp_due.delete();
    end else begin
      if (cfg_we) size_reg = cfg_wdata;
      if (rsp_valid && rsp_ready) begin
        responses++;
        if (rsp_due.size() == 0) begin
          note_mismatch("response with no request open", '0, '0);
        end else begin
          want = rsp_due.pop_front();
          if (rsp.bus_tx_byte !== want.bus_tx_byte)
            note_mismatch("bus_tx_byte", rsp.bus_tx_byte, want.bus_tx_byte);
          if (rsp.host_read_data !== want.host_read_data)
            note_mismatch("host_read_data", rsp.host_read_data, want.host_read_data);
          if (rsp.internal_address !== want.internal_address)
            note_mismatch("internal_address", rsp.internal_address, want.internal_address);
          if (rsp.rx_done !== want.rx_done)
            note_mismatch("rx_done", rsp.rx_done, want.rx_done);
          if (rsp.tx_done !== want.tx_done)
            note_mismatch("tx_done", rsp.tx_done, want.tx_done);
          if (rsp.general_call_seen !== want.general_call_seen)
            note_mismatch("general_call_seen", rsp.general_call_seen, want.general_call_seen);
          if (rsp.pointer !== want.pointer)
            note_mismatch("pointer", rsp.pointer, want.pointer);
        end
      end
      if (req_valid && req_ready) begin
        advance_slave(req, fresh);
        rsp_due.push_back(fresh);
      end
    end
    open_count <= rsp_due.size();
    fail_total <= mismatches;
  end

endmodule

@@ dv/i2c_slave_buffer_responder_unit_tb.sv @@
`timescale 1ns / 1ps
module i2c_slave_buffer_responder_unit_tb;
  import i2csbr_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int PHASE_ITEMS = 50;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             req_valid = 1'b0;
  logic             req_ready;
  req_t             req = '0;
  logic             rsp_valid;
  logic             rsp_ready = 1'b1;
  rsp_t             rsp;
  logic             cfg_we = 1'b0;
  logic [PTR_W-1:0] cfg_wdata = '0;

  logic calm = 1'b0;
  int   stall_left = 0;
  int   quiet = 0;
  int   fail_total;
  int   open_count;
  int   sent = 0;
  int   cur_bound = 0;

  always #1 clk = ~clk;

  i2c_slave_buffer_responder_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  i2c_slave_buffer_responder_unit_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_total (fail_total),
    .open_count (open_count)
  );

  always @(posedge clk) begin
    if (rst || calm) begin
      rsp_ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      rsp_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      rsp_ready <= 1'b0;
      stall_left <= $urandom_range(0, 8);
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet == QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Fields that the mode does not use carry random values.
  function automatic req_t cmd(input logic [3:0] m, input logic [7:0] a = 8'h00,
                               input logic [7:0] d = 8'h00);
    req_t r;
    r.mode = m;
    r.bus_byte = 8'($urandom);
    r.host_index = 8'($urandom);
    r.host_data = 8'($urandom);
    r.flag_select = 2'($urandom);
    r.flag_value = 1'($urandom);
    case (m)
      MODE_BYTE_RX: r.bus_byte = a;
      MODE_HOST_RD: r.host_index = a;
      MODE_HOST_WR: begin
        r.host_index = a;
        r.host_data = d;
      end
      MODE_SET_FLAG: begin
        r.flag_select = a[1:0];
        r.flag_value = d[0];
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic issue(input req_t r);
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_ready !== 1'b1);
    sent++;
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_size(input logic [PTR_W-1:0] v);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_bound = (v > DEPTH_PTR) ? DEPTH : int'(v);
  endtask

  function automatic logic [7:0] pick_address();
    if (cur_bound > 0 && $urandom_range(0, 4) != 0) return 8'($urandom_range(0, cur_bound - 1));
    return 8'($urandom);
  endfunction

  function automatic int pick_length();
    if ($urandom_range(0, 7) == 0) return $urandom_range(8, 24);
    return $urandom_range(0, 6);
  endfunction

  task automatic write_burst();
    int n;
    n = pick_length();
    issue(cmd(MODE_START));
    issue(cmd(MODE_BYTE_RX, pick_address()));
    repeat (n) issue(cmd(MODE_BYTE_RX, 8'($urandom)));
    if ($urandom_range(0, 6) != 0) issue(cmd(MODE_STOP));
  endtask

  task automatic read_burst();
    int n;
    n = pick_length();
    issue(cmd(MODE_START));
    if ($urandom_range(0, 9) < 7) begin
      issue(cmd(MODE_BYTE_RX, pick_address()));
      issue(cmd(MODE_START));
    end
    repeat (n) issue(cmd(MODE_BYTE_REQ));
    if ($urandom_range(0, 6) != 0) issue(cmd(MODE_STOP));
  endtask

  task automatic stray_request();
    case ($urandom_range(0, 9))
      0: issue(cmd(MODE_HOST_RD, 8'($urandom)));
      1: issue(cmd(MODE_HOST_WR, 8'($urandom), 8'($urandom)));
      2: issue(cmd(MODE_GEN_CALL));
      3: issue(cmd(MODE_SET_FLAG, 8'($urandom_range(0, 3)), 8'($urandom)));
      4: issue(cmd(MODE_ARM));
      5: issue(cmd(4'($urandom_range(9, 15))));
      6: issue(cmd(MODE_BYTE_RX, 8'($urandom)));
      7: issue(cmd(MODE_BYTE_REQ));
      8: issue(cmd(MODE_STOP));
      default: issue(cmd(MODE_START));
    endcase
  endtask

  initial begin
    logic [PTR_W-1:0] sizes [8];
    int               target;
    int               kind;
    sizes = '{9'd16, 9'd256, 9'd1, 9'd0, 9'd40, 9'd511, 9'd200, 9'd8};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    set_size(9'd4);

    // Every entry is written once so that no later read touches undefined storage.
    for (int k = 0; k < DEPTH; k++) issue(cmd(MODE_HOST_WR, 8'(k), 8'($urandom)));

    // Write transaction that overruns a four-byte buffer.
    issue(cmd(MODE_START));
    issue(cmd(MODE_BYTE_RX, 8'd2));
    issue(cmd(MODE_BYTE_RX, 8'hFF));
    issue(cmd(MODE_BYTE_RX, 8'h00));
    issue(cmd(MODE_BYTE_RX, 8'hA5));
    issue(cmd(MODE_STOP));
    // Out-of-range address, then a read that runs past the end.
    issue(cmd(MODE_START));
    issue(cmd(MODE_BYTE_RX, 8'd9));
    issue(cmd(MODE_START));
    repeat (4) issue(cmd(MODE_BYTE_REQ));
    issue(cmd(MODE_BYTE_REQ));
    issue(cmd(MODE_STOP));
    // Flags, host access at both ends of the buffer, and an unused mode.
    issue(cmd(MODE_GEN_CALL));
    issue(cmd(MODE_SET_FLAG, 8'd3, 8'd1));
    issue(cmd(MODE_SET_FLAG, FLAG_RX_DONE, 8'd0));
    issue(cmd(MODE_SET_FLAG, FLAG_TX_DONE, 8'd1));
    issue(cmd(MODE_SET_FLAG, FLAG_GC, 8'd0));
    issue(cmd(MODE_ARM));
    issue(cmd(MODE_HOST_WR, 8'hFF, 8'h00));
    issue(cmd(MODE_HOST_RD, 8'hFF));
    issue(cmd(MODE_HOST_RD, 8'h00));
    issue(cmd(4'd15));
    issue(cmd(MODE_BYTE_REQ));

    foreach (sizes[p]) begin
      set_size(sizes[p]);
      if (p == 7) calm <= 1'b1;
      target = sent + PHASE_ITEMS;
      while (sent < target) begin
        kind = $urandom_range(0, 9);
        if (kind < 4) write_burst();
        else if (kind < 7) read_burst();
        else stray_request();
        if (p != 7 && $urandom_range(0, 39) == 0) settle();
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (fail_total == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
